// File: rtl/trex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trex_pkg;

    localparam int ACT_W     = 3;
    localparam int IDX_W     = 3;
    localparam int IMM_W     = 12;
    localparam int PC_OUT_W  = 7;
    localparam int VAL_OUT_W = 32;

    // offset that moves the signed immediate onto 0 .. 2**IMM_W-1
    localparam int IMM_BIAS  = 1 << (IMM_W - 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_ADDI,
        ACT_ADD,
        ACT_SUB,
        ACT_BEQ,
        ACT_BGE,
        ACT_END
    } t_action;

    typedef struct packed {
        t_action          action;
        logic [IDX_W-1:0] dest_reg;
        logic [IDX_W-1:0] src_reg_a;
        logic [IDX_W-1:0] src_reg_b;
        logic [IMM_W-1:0] immediate;
    } t_instr;

    typedef struct packed {
        logic   valid;
        t_instr instr;
    } t_stage;

endpackage

`default_nettype wire

// File: rtl/trex_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface trex_instr_if;
    import trex_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [IDX_W-1:0]        dest_reg;
    logic [IDX_W-1:0]        src_reg_a;
    logic [IDX_W-1:0]        src_reg_b;
    logic signed [IMM_W-1:0] immediate;

    modport source (output valid, action, dest_reg, src_reg_a, src_reg_b, immediate,
                    input ready);
    modport sink   (input valid, action, dest_reg, src_reg_a, src_reg_b, immediate,
                    output ready);
endinterface

interface trex_result_if;
    import trex_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [PC_OUT_W-1:0]         next_pc;
    logic                        wrote;
    logic [IDX_W-1:0]            write_reg;
    logic signed [VAL_OUT_W-1:0] write_value;
    logic                        branch_taken;
    logic                        halted;

    modport source (output valid, next_pc, wrote, write_reg, write_value, branch_taken,
                    halted, input ready);
    modport sink   (input valid, next_pc, wrote, write_reg, write_value, branch_taken,
                    halted, output ready);
endinterface

`default_nettype wire

// File: rtl/trex_offset_prep.sv
`timescale 1ns / 1ps
`default_nettype none

module trex_offset_prep #(
    parameter int PROGRAM_DEPTH = 128
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_advance,
    trex_instr_if.sink                              i_instr,
    output trex_pkg::t_stage                        o_s1,
    output trex_pkg::t_stage                        o_s2,
    output logic [$clog2(PROGRAM_DEPTH)-1:0]        o_offset
);
    import trex_pkg::*;

    localparam int PC_W   = $clog2(PROGRAM_DEPTH);
    // reciprocal for an exact floor(u / depth) over 12-bit u
    localparam int SHIFT  = IMM_W + PC_W;
    localparam int RCP_W  = IMM_W + 2;
    localparam longint unsigned RCP_L =
        ((64'd1 << SHIFT) + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH;
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);
    localparam int PROD_W = IMM_W + RCP_W;
    localparam int OW     = ((PC_W > IMM_W) ? PC_W : IMM_W) + 1;
    localparam int QD_W   = IMM_W + OW;
    localparam logic [OW-1:0] DEPTH_O  = OW'(PROGRAM_DEPTH);
    localparam logic [OW-1:0] BIAS_RES = OW'(IMM_BIAS % PROGRAM_DEPTH);

    t_stage              r_s1;
    t_stage              r_s2;
    logic [IMM_W-1:0]    r_q;
    logic [PC_W-1:0]     r_off;

    logic [IMM_W-1:0]    w_in_u;
    logic [PROD_W-1:0]   w_prod;
    logic [IMM_W-1:0]    n_q;
    t_instr              w_in_instr;
    logic [IMM_W-1:0]    w_s1_u;
    logic [QD_W-1:0]     w_qd;
    logic [OW-1:0]       w_rem;
    logic [OW-1:0]       w_off_full;
    logic [PC_W-1:0]     n_off;

    assign i_instr.ready = i_advance;

    always_comb begin
        w_in_instr.action    = t_action'(i_instr.action);
        w_in_instr.dest_reg  = i_instr.dest_reg;
        w_in_instr.src_reg_a = i_instr.src_reg_a;
        w_in_instr.src_reg_b = i_instr.src_reg_b;
        w_in_instr.immediate = i_instr.immediate;
    end

    // biased immediate: flip the sign bit
    assign w_in_u = {~i_instr.immediate[IMM_W-1], i_instr.immediate[IMM_W-2:0]};
    assign w_prod = PROD_W'(w_in_u) * PROD_W'(RCP);
    assign n_q    = IMM_W'(w_prod >> SHIFT);

    // remainder, then undo the bias modulo the depth
    assign w_s1_u     = {~r_s1.instr.immediate[IMM_W-1], r_s1.instr.immediate[IMM_W-2:0]};
    assign w_qd       = QD_W'(r_q) * QD_W'(PROGRAM_DEPTH);
    assign w_rem      = OW'(w_s1_u - IMM_W'(w_qd));
    assign w_off_full = (w_rem >= BIAS_RES) ? (w_rem - BIAS_RES)
                                            : (w_rem + DEPTH_O - BIAS_RES);
    assign n_off      = PC_W'(w_off_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else if (i_advance) begin
            r_s1.valid <= i_instr.valid;
            r_s2.valid <= r_s1.valid;
            r_s1.instr <= w_in_instr;
            r_q        <= n_q;
            r_s2.instr <= r_s1.instr;
            r_off      <= n_off;
        end
    end

    assign o_s1     = r_s1;
    assign o_s2     = r_s2;
    assign o_offset = r_off;

endmodule

`default_nettype wire

// File: rtl/trex_core.sv
`timescale 1ns / 1ps
`default_nettype none

module trex_core #(
    parameter int NUM_REGS      = 8,
    parameter int PROGRAM_DEPTH = 128,
    parameter int DATA_WIDTH    = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire trex_pkg::t_stage                   i_s1,
    input  wire trex_pkg::t_stage                   i_s2,
    input  wire logic [$clog2(PROGRAM_DEPTH)-1:0]   i_offset,
    output logic                                    o_advance,
    trex_result_if.source                           o_result
);
    import trex_pkg::*;

    localparam int RIDX_W = $clog2(NUM_REGS);
    localparam int PC_W   = $clog2(PROGRAM_DEPTH);
    localparam logic [PC_W:0] DEPTH_P = (PC_W + 1)'(PROGRAM_DEPTH);

    function automatic logic [RIDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] f);
        logic [RIDX_W-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << IDX_W); k++) begin
            if (f == IDX_W'(k)) begin
                r = RIDX_W'(k % NUM_REGS);
            end
        end
        return r;
    endfunction

    logic [DATA_WIDTH-1:0] r_rf [NUM_REGS];
    logic [NUM_REGS-1:0]   r_vld;
    logic [DATA_WIDTH-1:0] r_va;
    logic [DATA_WIDTH-1:0] r_vb;
    logic [PC_W-1:0]       r_pc;
    logic                  r_halted;

    logic                  r_out_valid;
    logic [PC_OUT_W-1:0]   r_out_pc;
    logic                  r_out_wrote;
    logic [IDX_W-1:0]      r_out_reg;
    logic [VAL_OUT_W-1:0]  r_out_value;
    logic                  r_out_taken;
    logic                  r_out_halted;

    logic [63:0]           w_imm64;
    logic [DATA_WIDTH-1:0] w_imm_ext;
    logic [DATA_WIDTH-1:0] w_value;
    logic                  w_wr;
    logic                  w_taken;
    logic                  w_end;
    logic                  w_do;
    logic                  w_wr_en;
    logic [RIDX_W-1:0]     w_rd;
    logic [RIDX_W-1:0]     w_ra1;
    logic [RIDX_W-1:0]     w_rb1;
    logic [PC_W:0]         w_inc;
    logic [PC_W:0]         w_sum;
    logic [PC_W-1:0]       w_pc_next;
    logic [PC_W-1:0]       w_pc_out;
    logic                  w_live_wr;

    assign o_advance = !r_out_valid || o_result.ready;

    assign w_imm64   = 64'($signed(i_s2.instr.immediate));
    assign w_imm_ext = w_imm64[DATA_WIDTH-1:0];

    always_comb begin
        w_value = '0;
        w_wr    = 1'b0;
        w_taken = 1'b0;
        w_end   = 1'b0;
        case (i_s2.instr.action)
            ACT_ADDI: begin
                w_value = r_va + w_imm_ext;
                w_wr    = 1'b1;
            end
            ACT_ADD: begin
                w_value = r_va + r_vb;
                w_wr    = 1'b1;
            end
            ACT_SUB: begin
                w_value = r_va - r_vb;
                w_wr    = 1'b1;
            end
            ACT_BEQ: begin
                w_taken = (r_va == r_vb);
            end
            ACT_BGE: begin
                w_taken = ($signed(r_va) >= $signed(r_vb));
            end
            default: begin
                // end, and the unused codes with it
                w_end = 1'b1;
            end
        endcase
    end

    assign w_do      = o_advance && i_s2.valid && !r_halted;
    assign w_wr_en   = w_do && w_wr;
    assign w_live_wr = !r_halted && w_wr;

    assign w_rd  = wrap_idx(i_s2.instr.dest_reg);
    assign w_ra1 = wrap_idx(i_s1.instr.src_reg_a);
    assign w_rb1 = wrap_idx(i_s1.instr.src_reg_b);

    assign w_inc     = w_taken ? {1'b0, i_offset} : (PC_W + 1)'(1);
    assign w_sum     = {1'b0, r_pc} + w_inc;
    assign w_pc_next = (w_sum >= DEPTH_P) ? PC_W'(w_sum - DEPTH_P) : PC_W'(w_sum);
    assign w_pc_out  = (r_halted || w_end) ? r_pc : w_pc_next;

    // register file
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_rf[w_rd] <= w_value;
        end
    end

    // operand read for the next stage, with the write of this cycle forwarded
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_va <= (w_wr_en && (w_rd == w_ra1)) ? w_value
                  : (r_vld[w_ra1] ? r_rf[w_ra1] : '0);
            r_vb <= (w_wr_en && (w_rd == w_rb1)) ? w_value
                  : (r_vld[w_rb1] ? r_rf[w_rb1] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_pc        <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_vld[w_rd] <= 1'b1;
            end
            if (w_do && !w_end) begin
                r_pc <= w_pc_next;
            end
            if (w_do && w_end) begin
                r_halted <= 1'b1;
            end
            if (o_advance) begin
                r_out_valid <= i_s2.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_s2.valid) begin
            r_out_pc     <= PC_OUT_W'(w_pc_out);
            r_out_wrote  <= w_live_wr;
            r_out_reg    <= w_live_wr ? IDX_W'(w_rd) : '0;
            r_out_value  <= w_live_wr ? VAL_OUT_W'(w_value) : '0;
            r_out_taken  <= !r_halted && w_taken;
            r_out_halted <= r_halted || w_end;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.next_pc      = r_out_pc;
    assign o_result.wrote        = r_out_wrote;
    assign o_result.write_reg    = r_out_reg;
    assign o_result.write_value  = r_out_value;
    assign o_result.branch_taken = r_out_taken;
    assign o_result.halted       = r_out_halted;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag cleared without reset");

    a_halt_pc_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> $stable(r_pc))
        else $error("counter moved while halted");

    a_halt_beat_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && i_s2.valid && r_halted) |=>
            (r_out_valid && !r_out_wrote && !r_out_taken && r_out_halted))
        else $error("beat issued while halted reports activity");

    a_wrote_not_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_wrote) |-> !r_out_halted)
        else $error("write reported on a halted beat");

endmodule

`default_nettype wire

// File: rtl/tiny_risc_execute_unit.sv
// Executes one decoded instruction (addi, add, sub, beq, bge, end) per beat against a
// file of NUM_REGS registers of DATA_WIDTH bits and a program counter modulo
// PROGRAM_DEPTH. Throughput is one instruction per clock while results are taken; the result
// beat is registered through branch-offset reduction in two stages, then the execute
// stage into the output register. The execute stage - 32-bit add/compare and counter
// update - uses operands read from the register file in the stage before, with its
// own write forwarded. The input side stalls only while a finished result is held
// and not taken. After an end the unit reports halted with the counter frozen until
// reset. Nothing is cleared after reset beyond the reset itself.
`timescale 1ns / 1ps
`default_nettype none

module tiny_risc_execute_unit #(
    parameter int NUM_REGS      = 8,
    parameter int PROGRAM_DEPTH = 128,
    parameter int DATA_WIDTH    = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    trex_instr_if.sink      i_instr,
    trex_result_if.source   o_result
);
    import trex_pkg::*;

    t_stage                             w_s1;
    t_stage                             w_s2;
    logic [$clog2(PROGRAM_DEPTH)-1:0]   w_offset;
    logic                               w_advance;

    trex_offset_prep #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_instr   (i_instr),
        .o_s1      (w_s1),
        .o_s2      (w_s2),
        .o_offset  (w_offset)
    );

    trex_core #(
        .NUM_REGS      (NUM_REGS),
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .DATA_WIDTH    (DATA_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (w_s1),
        .i_s2      (w_s2),
        .i_offset  (w_offset),
        .o_advance (w_advance),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire
